@@ hw/rtl/rhce_pkg.sv @@
// Package for the record header check engine: payload structs, register
// indexes, CRC-32C constants and the byte and word fold functions.
// No dependencies.
package rhce_pkg;

    localparam logic [31:0] CRC32C_POLY = 32'h82F6_3B78;
    localparam logic [31:0] CRC_INIT    = 32'hFFFF_FFFF;
    localparam logic [15:0] BASE_SIZE   = 16'd6;

    // Configuration register indexes.
    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SIZE_FIELD_MASK = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SIZE4_CODE      = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SIZE8_CODE      = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_CRC_FLAG_MASK   = 2'd3;

    localparam logic [7:0] RST_SIZE_FIELD_MASK = 8'd3;
    localparam logic [7:0] RST_SIZE4_CODE      = 8'd1;
    localparam logic [7:0] RST_SIZE8_CODE      = 8'd3;
    localparam logic [7:0] RST_CRC_FLAG_MASK   = 8'd4;

    // Request types.
    localparam logic REQ_HEADER = 1'b0;
    localparam logic REQ_DATA   = 1'b1;

    typedef struct packed {
        logic        req_type;
        logic [7:0]  rec_type;
        logic [7:0]  rec_flags;
        logic [15:0] head_size;
        logic [63:0] added_size;
        logic [31:0] added_crc;
        logic [15:0] expected_crc;
        logic [15:0] data_length;
        logic        fix_mode;
        logic [7:0]  data_byte;
        logic        last_byte;
    } t_in_item;

    typedef struct packed {
        logic [15:0] check_value;
        logic [15:0] size_out;
        logic        matches_res;
    } t_out_item;

    // Reflected CRC-32C update by one byte.
    function automatic logic [31:0] fold_byte(input logic [31:0] crc_in,
                                              input logic [7:0]  data);
        logic [31:0] c;
        c = crc_in ^ {24'd0, data};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC32C_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // Four bytes, least significant byte first.
    function automatic logic [31:0] fold_word(input logic [31:0] crc_in,
                                              input logic [31:0] word);
        logic [31:0] c;
        c = fold_byte(crc_in, word[7:0]);
        c = fold_byte(c, word[15:8]);
        c = fold_byte(c, word[23:16]);
        c = fold_byte(c, word[31:24]);
        return c;
    endfunction

endpackage

@@ hw/rtl/record_header_crc_engine.sv @@
// Top level of the record header check engine: input register, header and
// data-byte CRC-32C logic, record state and result register.
// Depends on rhce_pkg.
//
//  channel   direction  handshake                 payload
//  in        input      i_in_valid / o_in_stall   i_in_data  (t_in_item)
//  out       output     o_out_valid / i_out_stall o_out_data (t_out_item)
//  cfg       input      i_cfg_we                  i_cfg_index, i_cfg_data
//
// One item is taken per cycle while the input is not stalled. An accepted
// item sits in the input register, where the whole header (up to sixteen
// bytes) or one data byte is folded into the CRC; its result, if any, is
// loaded into the output register when the stage advances. A stalled
// output holds the processing stage, and the input stalls only while both
// registers are full and the output is stalled. Reset is synchronous and
// restores the register defaults and closes any open record.
module record_header_crc_engine (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  rhce_pkg::t_in_item                  i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output rhce_pkg::t_out_item                 o_out_data,
    input  logic                                i_cfg_we,
    input  logic [rhce_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [7:0]                          i_cfg_data
);
    import rhce_pkg::*;

    logic [7:0]  r_size_field_mask;
    logic [7:0]  r_size4_code;
    logic [7:0]  r_size8_code;
    logic [7:0]  r_crc_flag_mask;

    logic        r_in_valid;
    t_in_item    r_in_q;
    logic        r_out_valid;
    t_out_item   r_out_q;

    logic [31:0] r_crc_accum;
    logic [15:0] r_expected_hold;
    logic [15:0] r_size_hold;
    logic        r_in_record;
    logic        r_fix_hold;

    logic [31:0] n_crc_accum;
    logic [15:0] n_expected_hold;
    logic [15:0] n_size_hold;
    logic        n_in_record;
    logic        n_fix_hold;
    logic        n_emit;
    t_out_item   n_out;

    logic        adv;
    logic [7:0]  sel;
    logic        add4;
    logic        add8;
    logic        has_crc;
    logic [15:0] derived_size;
    logic [15:0] hsize;
    logic [31:0] crc_base;
    logic [31:0] crc_a4;
    logic [31:0] crc_a8;
    logic [31:0] crc_sized;
    logic [31:0] crc_head;
    logic [31:0] crc_data;
    logic [15:0] chk;

    // The processing stage moves whenever it holds an item and the result register can be loaded.
    assign adv        = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !adv;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_field_mask <= RST_SIZE_FIELD_MASK;
            r_size4_code      <= RST_SIZE4_CODE;
            r_size8_code      <= RST_SIZE8_CODE;
            r_crc_flag_mask   <= RST_CRC_FLAG_MASK;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SIZE_FIELD_MASK: r_size_field_mask <= i_cfg_data;
                CFG_SIZE4_CODE:      r_size4_code      <= i_cfg_data;
                CFG_SIZE8_CODE:      r_size8_code      <= i_cfg_data;
                CFG_CRC_FLAG_MASK:   r_crc_flag_mask   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Header decode and CRC.
    always_comb begin
        sel     = r_in_q.rec_flags & r_size_field_mask;
        add4    = (sel == r_size4_code);
        add8    = !add4 && (sel == r_size8_code);
        has_crc = |(r_in_q.rec_flags & r_crc_flag_mask);
        derived_size = BASE_SIZE + r_in_q.data_length
                     + (add4 ? 16'd4 : (add8 ? 16'd8 : 16'd0))
                     + (has_crc ? 16'd4 : 16'd0);
        hsize = r_in_q.fix_mode ? derived_size : r_in_q.head_size;

        crc_base  = fold_word(CRC_INIT,
                              {hsize[15:8], hsize[7:0], r_in_q.rec_flags, r_in_q.rec_type});
        crc_a4    = fold_word(crc_base, r_in_q.added_size[31:0]);
        crc_a8    = fold_word(crc_a4, r_in_q.added_size[63:32]);
        crc_sized = add4 ? crc_a4 : (add8 ? crc_a8 : crc_base);
        crc_head  = has_crc ? fold_word(crc_sized, r_in_q.added_crc) : crc_sized;
        crc_data  = fold_byte(r_crc_accum, r_in_q.data_byte);
    end

    // Record state update and result.
    always_comb begin
        n_crc_accum     = r_crc_accum;
        n_expected_hold = r_expected_hold;
        n_size_hold     = r_size_hold;
        n_in_record     = r_in_record;
        n_fix_hold      = r_fix_hold;
        n_emit          = 1'b0;
        if (r_in_q.req_type == REQ_HEADER) begin
            n_crc_accum     = crc_head;
            n_expected_hold = r_in_q.expected_crc;
            n_size_hold     = hsize;
            n_fix_hold      = r_in_q.fix_mode;
            n_in_record     = (r_in_q.data_length != 16'd0);
            n_emit          = (r_in_q.data_length == 16'd0);
        end else if (r_in_record) begin
            n_crc_accum = crc_data;
            if (r_in_q.last_byte) begin
                n_in_record = 1'b0;
                n_emit      = 1'b1;
            end
        end
        chk               = ~n_crc_accum[15:0];
        n_out.check_value = chk;
        n_out.size_out    = n_size_hold;
        n_out.matches_res = n_fix_hold || (chk == n_expected_hold);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid      <= 1'b0;
            r_out_valid     <= 1'b0;
            r_in_record     <= 1'b0;
            r_fix_hold      <= 1'b0;
            r_crc_accum     <= 32'd0;
            r_expected_hold <= 16'd0;
            r_size_hold     <= 16'd0;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (adv) begin
                r_crc_accum     <= n_crc_accum;
                r_expected_hold <= n_expected_hold;
                r_size_hold     <= n_size_hold;
                r_in_record     <= n_in_record;
                r_fix_hold      <= n_fix_hold;
                r_out_valid     <= n_emit;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_q <= i_in_data;
        end
        if (adv && n_emit) begin
            r_out_q <= n_out;
        end
    end

    a_reset_closes: assert property (@(posedge i_clk) !i_rst_n |=> !r_in_record)
        else $error("record left open after reset");

    a_stall_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_out_valid))
        else $error("input stalled with an empty stage");

    a_last_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_in_q.req_type == REQ_DATA && r_in_record && r_in_q.last_byte)
        |=> (!r_in_record && r_out_valid))
        else $error("last data byte did not close the record with a result");

    a_orphan_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_in_q.req_type == REQ_DATA && !r_in_record)
        |=> (!r_out_valid && $stable(r_crc_accum)))
        else $error("data byte outside a record changed state");

endmodule
